FILE: rtl/core/qdtq_pkg.sv
// ----------------------------------------------------------------------------
// qdtq_pkg - shared types and constants of the detent tap queue
// Payload structs, operation and register codes, the quadrature step table
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package qdtq_pkg;

  localparam int unsigned ActionWidth = 16;
  localparam int unsigned SpdWidth    = 4;
  localparam int unsigned CfgIdxWidth = 3;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_LOAD   = 2'd2;

  localparam logic [CfgIdxWidth-1:0] CFG_ENC0_CW  = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_ENC0_CCW = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_ENC1_CW  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_ENC1_CCW = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CFG_SPD      = 3'd4;

  localparam logic [ActionWidth-1:0] RST_ENC0_CW  = 16'h004F;
  localparam logic [ActionWidth-1:0] RST_ENC0_CCW = 16'h0050;
  localparam logic [ActionWidth-1:0] RST_ENC1_CW  = 16'h0052;
  localparam logic [ActionWidth-1:0] RST_ENC1_CCW = 16'h0051;
  localparam logic [SpdWidth-1:0]    RST_SPD      = 4'd4;

  typedef struct packed {
    logic [1:0] operation;
    logic       encoder_select;
    logic [1:0] phase_bits;
    logic       report_slot_free;
  } in_t;

  typedef struct packed {
    logic       tap_valid;
    logic [7:0] tap_mods;
    logic [7:0] tap_key;
    logic       queue_empty;
    logic       queue_overflowed;
  } out_t;

  typedef struct packed {
    logic load_item;
    logic exec_simple;
    logic settle;
    logic div_step;
    logic push;
    logic pop;
    logic emit;
    logic enc;
  } cmd_t;

  typedef struct packed {
    logic item_tick;
    logic need_push;
    logic div_last;
    logic n_zero;
    logic out_free;
  } sts_t;

  // index is previous phase then new phase
  function automatic logic signed [1:0] step_lut(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  s = 2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = -2'sd1;
      default:                  s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/quadrature_detent_tap_queue.sv
// ----------------------------------------------------------------------------
// quadrature_detent_tap_queue - two-encoder quadrature decoder with tap ring
// Counts 4x quadrature steps per encoder, turns whole detents into key
// actions queued in a ring, and pops at most one action per frame tick.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry one in_t item; one out_t result follows each
//   item on out_valid/out_stall. cfg_we/cfg_index/cfg_data write the action
//   and steps-per-detent registers while the block is idle.
//   Phase sample, phase load and unused codes pass through accept, execute
//   and result steps; the result is shown in the cycle after the result step.
//   A tick settles each encoder in turn; where whole detents are pending,
//   the detent count is found by a one-bit-per-cycle divider and taps are
//   written into the ring one per cycle; taps beyond a full ring are dropped.
//   The ring is a QUEUE_DEPTH-entry memory holding up to QUEUE_DEPTH-1 taps.
//   Reset (synchronous) clears counts and indices and loads the default
//   configuration; the ring needs no clearing pass. While the receiver stalls,
//   the finished result is held and one more item may be accepted and worked
//   on; its result waits until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_detent_tap_queue #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire qdtq_pkg::in_t                    in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output qdtq_pkg::out_t                        out_data,
  input  wire logic                             cfg_we,
  input  wire logic [qdtq_pkg::CfgIdxWidth-1:0] cfg_index,
  input  wire logic [qdtq_pkg::ActionWidth-1:0] cfg_data
);

  qdtq_pkg::cmd_t cmd;
  qdtq_pkg::sts_t sts;

  qdtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  qdtq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

FILE: rtl/core/qdtq_ctrl.sv
// ----------------------------------------------------------------------------
// qdtq_ctrl - sequencer of the detent tap queue
// Walks each item through execute and, for a tick, per-encoder settle,
// divide and push, then pop; every item ends with the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module qdtq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire qdtq_pkg::sts_t sts,
  output qdtq_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SETTLE = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_PUSH   = 3'd4;
  localparam logic [2:0] S_POP    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       enc_r, enc_nxt;

  always_comb begin
    state_nxt = state_r;
    enc_nxt   = enc_r;
    cmd       = '0;
    cmd.enc   = enc_r;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.item_tick) begin
          enc_nxt   = 1'b0;
          state_nxt = S_SETTLE;
        end else begin
          cmd.exec_simple = 1'b1;
          state_nxt       = S_FINISH;
        end
      end
      S_SETTLE: begin
        cmd.settle = 1'b1;
        if (sts.need_push) begin
          state_nxt = S_DIV;
        end else if (!enc_r) begin
          enc_nxt = 1'b1;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        if (sts.n_zero) begin
          if (!enc_r) begin
            enc_nxt   = 1'b1;
            state_nxt = S_SETTLE;
          end else begin
            state_nxt = S_POP;
          end
        end
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      enc_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      enc_r   <= enc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/qdtq_datapath.sv
// ----------------------------------------------------------------------------
// qdtq_datapath - counters, detent divider, tap ring and result register
// Holds encoder state and configuration, a bit-serial detent divider, the
// tap ring memory and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qdtq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire qdtq_pkg::in_t                        in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output qdtq_pkg::out_t                            out_data,
  input  wire logic                                 cfg_we,
  input  wire logic [qdtq_pkg::CfgIdxWidth-1:0]     cfg_index,
  input  wire logic [qdtq_pkg::ActionWidth-1:0]     cfg_data,
  input  wire qdtq_pkg::cmd_t                       cmd,
  output qdtq_pkg::sts_t                            sts
);

  localparam int unsigned W     = COUNT_WIDTH;
  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned DCW   = $clog2(COUNT_WIDTH + 1);
  localparam int unsigned SW    = qdtq_pkg::SpdWidth;
  localparam int unsigned AW    = qdtq_pkg::ActionWidth;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0]   s;
    logic [W-1:0] r;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      r = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      r = s[W-1:0];
    end
    return r;
  endfunction

  // configuration
  logic [AW-1:0] enc0_cw_r, enc0_ccw_r, enc1_cw_r, enc1_ccw_r;
  logic [SW-1:0] spd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc0_cw_r  <= qdtq_pkg::RST_ENC0_CW;
      enc0_ccw_r <= qdtq_pkg::RST_ENC0_CCW;
      enc1_cw_r  <= qdtq_pkg::RST_ENC1_CW;
      enc1_ccw_r <= qdtq_pkg::RST_ENC1_CCW;
      spd_r      <= qdtq_pkg::RST_SPD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qdtq_pkg::CFG_ENC0_CW:  enc0_cw_r  <= cfg_data;
        qdtq_pkg::CFG_ENC0_CCW: enc0_ccw_r <= cfg_data;
        qdtq_pkg::CFG_ENC1_CW:  enc1_cw_r  <= cfg_data;
        qdtq_pkg::CFG_ENC1_CCW: enc1_ccw_r <= cfg_data;
        qdtq_pkg::CFG_SPD:      spd_r      <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  // zero steps per detent acts as one
  logic [SW-1:0] spd_eff;
  assign spd_eff = (spd_r == '0) ? SW'(1) : spd_r;

  // item and encoder state
  qdtq_pkg::in_t item_r;
  logic [1:0]    last_phase_r [2];
  logic [W-1:0]  pending_r    [2];
  logic [W-1:0]  acc_r        [2];

  // divider and push count
  logic [W-1:0]   q_r;
  logic [SW-1:0]  rem_r;
  logic [DCW-1:0] div_cnt_r;
  logic           dir_neg_r;

  // ring
  logic [AW-1:0]    ring_mem [QUEUE_DEPTH];
  logic [IDX_W-1:0] wr_r, rd_r, count_r;
  logic [AW-1:0]    rdata_r;
  logic             ovf_r, tap_valid_r;

  // sample path
  logic signed [1:0] step;
  logic [W-1:0]      step_ext;
  assign step     = qdtq_pkg::step_lut({last_phase_r[item_r.encoder_select], item_r.phase_bits});
  assign step_ext = {{(W-2){step[1]}}, step};

  // settle path
  logic        [W-1:0] acc_sum;
  logic signed [W-1:0] spd_s;
  logic                pos, neg;
  logic        [W-1:0] mag;
  assign acc_sum = sat_add(acc_r[cmd.enc], pending_r[cmd.enc]);
  assign spd_s   = $signed({{(W-SW){1'b0}}, spd_eff});
  assign pos     = $signed(acc_sum) >= spd_s;
  assign neg     = $signed(acc_sum) <= -spd_s;
  assign mag     = pos ? acc_sum : (W'(0) - acc_sum);

  // divider step
  logic [SW:0]   rem_sh;
  logic          q_bit;
  logic [SW-1:0] rem_next;
  assign rem_sh   = {rem_r, q_r[W-1]};
  assign q_bit    = rem_sh >= {1'b0, spd_eff};
  assign rem_next = q_bit ? SW'(rem_sh - {1'b0, spd_eff}) : rem_sh[SW-1:0];

  logic [W-1:0] rem_ext;
  assign rem_ext = {{(W-SW){1'b0}}, rem_r};

  logic          ring_full, push_do, pop_do;
  logic [AW-1:0] push_action;
  assign ring_full   = count_r == IDX_LAST;
  assign push_do     = cmd.push && (q_r != '0) && !ring_full;
  assign pop_do      = cmd.pop && item_r.report_slot_free && (count_r != '0);
  assign push_action = cmd.enc ? (dir_neg_r ? enc1_ccw_r : enc1_cw_r)
                               : (dir_neg_r ? enc0_ccw_r : enc0_cw_r);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.settle) begin
      q_r       <= mag;
      rem_r     <= '0;
      div_cnt_r <= DCW'(COUNT_WIDTH);
      dir_neg_r <= !pos;
    end else if (cmd.div_step) begin
      q_r       <= {q_r[W-2:0], q_bit};
      rem_r     <= rem_next;
      div_cnt_r <= div_cnt_r - DCW'(1);
    end else if (cmd.push && (q_r != '0)) begin
      q_r <= ring_full ? '0 : (q_r - W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (push_do) begin
      ring_mem[wr_r] <= push_action;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_do) begin
      rdata_r <= ring_mem[rd_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        last_phase_r[i] <= '0;
        pending_r[i]    <= '0;
        acc_r[i]        <= '0;
      end
      wr_r        <= '0;
      rd_r        <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      tap_valid_r <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        ovf_r       <= 1'b0;
        tap_valid_r <= 1'b0;
      end
      if (cmd.exec_simple) begin
        if (item_r.operation == qdtq_pkg::OP_SAMPLE) begin
          pending_r[item_r.encoder_select] <=
            sat_add(pending_r[item_r.encoder_select], step_ext);
          last_phase_r[item_r.encoder_select] <= item_r.phase_bits;
        end else if (item_r.operation == qdtq_pkg::OP_LOAD) begin
          last_phase_r[item_r.encoder_select] <= item_r.phase_bits;
        end
      end
      if (cmd.settle) begin
        pending_r[cmd.enc] <= '0;
        acc_r[cmd.enc]     <= acc_sum;
      end
      if (cmd.push) begin
        acc_r[cmd.enc] <= dir_neg_r ? (W'(0) - rem_ext) : rem_ext;
        if ((q_r != '0) && ring_full) begin
          ovf_r <= 1'b1;
        end
      end
      if (push_do) begin
        wr_r    <= (wr_r == IDX_LAST) ? '0 : (wr_r + IDX_W'(1));
        count_r <= count_r + IDX_W'(1);
      end
      if (pop_do) begin
        rd_r        <= (rd_r == IDX_LAST) ? '0 : (rd_r + IDX_W'(1));
        count_r     <= count_r - IDX_W'(1);
        tap_valid_r <= 1'b1;
      end
    end
  end

  // result register
  logic out_valid_r;
  qdtq_pkg::out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.tap_valid        <= tap_valid_r;
      out_data_r.tap_mods         <= tap_valid_r ? rdata_r[15:8] : 8'd0;
      out_data_r.tap_key          <= tap_valid_r ? rdata_r[7:0] : 8'd0;
      out_data_r.queue_empty      <= count_r == '0;
      out_data_r.queue_overflowed <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.item_tick = item_r.operation == qdtq_pkg::OP_TICK;
  assign sts.need_push = pos || neg;
  assign sts.div_last  = div_cnt_r == DCW'(1);
  assign sts.n_zero    = q_r == '0;
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

FILE: rtl/core/qdtq_checker.sv
// ----------------------------------------------------------------------------
// qdtq_checker - port-level checks of the detent tap queue
// Output hold under stall, one item in flight, and empty tap fields.
// ----------------------------------------------------------------------------
`default_nettype none

module qdtq_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire qdtq_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  a_no_tap_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.tap_valid |-> out_data.tap_mods == 8'd0 && out_data.tap_key == 8'd0)
    else $error("tap fields set without a tap");

endmodule

bind quadrature_detent_tap_queue qdtq_checker u_qdtq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

FILE: test/quadrature_detent_tap_queue_test.sv
// ----------------------------------------------------------------------------
// quadrature_detent_tap_queue_test - self-checking bench for the tap queue
// Drives phase samples, phase loads and frame ticks through the input
// channel and checks every result against a cycle-free model of the two
// decoders, the detent accumulators and the tap ring (for fixed table rows,
// their own result). Hand-picked table items come first, then a run that
// overfills and drains the tap ring, then randomised rotation traffic
// under several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------

module quadrature_detent_tap_queue_test;

  localparam int RingDepth = 32;
  localparam int CntMax    = 32767;
  localparam int CntMin    = -32768;
  localparam int FillRun   = 40;
  localparam int DirRows   = 22;
  localparam int RandRun   = 72;

  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic           fixed;
    qdtq_pkg::in_t  item;
    qdtq_pkg::out_t res;
  } dir_row_t;

  localparam qdtq_pkg::out_t ResIdle = {1'b0, 16'h0000, 1'b1, 1'b0};
  localparam qdtq_pkg::out_t ResHeld = {1'b0, 16'h0000, 1'b0, 1'b0};

  localparam dir_row_t DirTab [DirRows] = '{
    {1'b1, OP_SPARE,            1'b1, 2'd3, 1'b1, ResIdle},
    {1'b1, qdtq_pkg::OP_TICK,   1'b0, 2'd0, 1'b1, ResIdle},
    {1'b1, qdtq_pkg::OP_LOAD,   1'b0, 2'd0, 1'b0, ResIdle},
    {1'b1, qdtq_pkg::OP_SAMPLE, 1'b0, 2'd1, 1'b0, ResIdle},
    {1'b1, qdtq_pkg::OP_SAMPLE, 1'b0, 2'd3, 1'b0, ResIdle},
    {1'b1, qdtq_pkg::OP_SAMPLE, 1'b0, 2'd2, 1'b0, ResIdle},
    {1'b1, qdtq_pkg::OP_SAMPLE, 1'b0, 2'd0, 1'b0, ResIdle},
    {1'b1, qdtq_pkg::OP_TICK,   1'b0, 2'd0, 1'b0, ResHeld},
    {1'b1, qdtq_pkg::OP_TICK,   1'b1, 2'd3, 1'b1, {1'b1, qdtq_pkg::RST_ENC0_CW, 1'b1, 1'b0}},
    {1'b1, qdtq_pkg::OP_LOAD,   1'b1, 2'd0, 1'b1, ResIdle},
    {1'b1, qdtq_pkg::OP_SAMPLE, 1'b1, 2'd2, 1'b0, ResIdle},
    {1'b1, qdtq_pkg::OP_SAMPLE, 1'b1, 2'd3, 1'b1, ResIdle},
    {1'b1, qdtq_pkg::OP_SAMPLE, 1'b1, 2'd1, 1'b0, ResIdle},
    {1'b1, qdtq_pkg::OP_SAMPLE, 1'b1, 2'd0, 1'b0, ResIdle},
    {1'b1, qdtq_pkg::OP_TICK,   1'b0, 2'd0, 1'b1, {1'b1, qdtq_pkg::RST_ENC1_CCW, 1'b1, 1'b0}},
    {1'b0, qdtq_pkg::OP_SAMPLE, 1'b0, 2'd3, 1'b0, ResIdle},
    {1'b0, qdtq_pkg::OP_SAMPLE, 1'b0, 2'd3, 1'b0, ResIdle},
    {1'b0, qdtq_pkg::OP_SAMPLE, 1'b0, 2'd1, 1'b0, ResIdle},
    {1'b0, qdtq_pkg::OP_LOAD,   1'b1, 2'd3, 1'b0, ResIdle},
    {1'b0, qdtq_pkg::OP_SAMPLE, 1'b1, 2'd1, 1'b1, ResIdle},
    {1'b0, qdtq_pkg::OP_TICK,   1'b1, 2'd2, 1'b1, ResIdle},
    {1'b1, OP_SPARE,            1'b0, 2'd0, 1'b0, ResIdle}
  };

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  qdtq_pkg::in_t                    in_data;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  qdtq_pkg::out_t                   out_data;
  logic                             cfg_we;
  logic [qdtq_pkg::CfgIdxWidth-1:0] cfg_index;
  logic [qdtq_pkg::ActionWidth-1:0] cfg_data;

  quadrature_detent_tap_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // model of the block
  logic [qdtq_pkg::ActionWidth-1:0] cw_action [2];
  logic [qdtq_pkg::ActionWidth-1:0] ccw_action [2];
  logic [qdtq_pkg::SpdWidth-1:0]    spd_reg;
  logic [1:0]                       phase_q [2];
  int                               pend_q [2];
  int                               detent_q [2];
  logic [qdtq_pkg::ActionWidth-1:0] ring_mem [RingDepth];
  logic [4:0]                       wr_idx;
  logic [4:0]                       rd_idx;

  qdtq_pkg::out_t tap_expect_q [$];
  qdtq_pkg::out_t want;
  int             err_count;
  bit             idle_en;
  bit             stall_en;
  int             stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [1:0] advance(logic [1:0] p, bit fwd);
    case (p)
      2'd0:    return fwd ? 2'd1 : 2'd2;
      2'd1:    return fwd ? 2'd3 : 2'd0;
      2'd3:    return fwd ? 2'd2 : 2'd1;
      default: return fwd ? 2'd0 : 2'd3;
    endcase
  endfunction

  function automatic int quad_step(logic [1:0] prev, logic [1:0] cur);
    if (cur == advance(prev, 1'b1)) return 1;
    if (cur == advance(prev, 1'b0)) return -1;
    return 0;
  endfunction

  function automatic int clamp_count(int v);
    if (v > CntMax) return CntMax;
    if (v < CntMin) return CntMin;
    return v;
  endfunction

  function automatic int ring_fill();
    logic [4:0] d;
    d = wr_idx - rd_idx;
    return int'(d);
  endfunction

  function automatic bit push_taps(logic [qdtq_pkg::ActionWidth-1:0] action, int n);
    int room;
    int take;
    int i;
    room = RingDepth - 1 - ring_fill();
    take = (n < room) ? n : room;
    for (i = 0; i < take; i++) begin
      ring_mem[wr_idx] = action;
      wr_idx = wr_idx + 5'd1;
    end
    return n > take;
  endfunction

  function automatic bit settle_enc(int e);
    int spd;
    int acc;
    int n;
    bit drop;
    spd = (spd_reg == '0) ? 1 : int'(spd_reg);
    acc = clamp_count(detent_q[e] + pend_q[e]);
    pend_q[e] = 0;
    drop = 1'b0;
    if (acc >= spd) begin
      n = acc / spd;
      acc -= n * spd;
      drop = push_taps(cw_action[e], n);
    end else if (acc <= -spd) begin
      n = (-acc) / spd;
      acc += n * spd;
      drop = push_taps(ccw_action[e], n);
    end
    detent_q[e] = acc;
    return drop;
  endfunction

  function automatic qdtq_pkg::out_t tap_outcome(qdtq_pkg::in_t it);
    qdtq_pkg::out_t                   r;
    logic [qdtq_pkg::ActionWidth-1:0] act;
    bit                               over;
    r = '0;
    act = '0;
    over = 1'b0;
    case (it.operation)
      qdtq_pkg::OP_SAMPLE: begin
        pend_q[it.encoder_select] = clamp_count(pend_q[it.encoder_select] +
          quad_step(phase_q[it.encoder_select], it.phase_bits));
        phase_q[it.encoder_select] = it.phase_bits;
      end
      qdtq_pkg::OP_LOAD: begin
        phase_q[it.encoder_select] = it.phase_bits;
      end
      qdtq_pkg::OP_TICK: begin
        if (settle_enc(0)) over = 1'b1;
        if (settle_enc(1)) over = 1'b1;
        if (it.report_slot_free && ring_fill() != 0) begin
          act = ring_mem[rd_idx];
          rd_idx = rd_idx + 5'd1;
          r.tap_valid = 1'b1;
        end
      end
      default: ;
    endcase
    r.tap_mods = act[15:8];
    r.tap_key = act[7:0];
    r.queue_empty = (ring_fill() == 0);
    r.queue_overflowed = over;
    return r;
  endfunction

  function automatic qdtq_pkg::in_t make_item(logic [1:0] op, logic e, logic [1:0] ph,
                                              logic slot);
    qdtq_pkg::in_t it;
    it.operation = op;
    it.encoder_select = e;
    it.phase_bits = ph;
    it.report_slot_free = slot;
    return it;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(qdtq_pkg::in_t it, logic use_fixed, qdtq_pkg::out_t fixed_res);
    int             gap;
    qdtq_pkg::out_t pred;
    gap = (idle_en && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_data = 6'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = tap_outcome(it);
    tap_expect_q.push_back(use_fixed ? fixed_res : pred);
  endtask

  task automatic send(qdtq_pkg::in_t it);
    send_item(it, 1'b0, ResIdle);
  endtask

  task automatic rotate(logic e, bit fwd, int steps);
    int k;
    for (k = 0; k < steps; k++)
      send(make_item(qdtq_pkg::OP_SAMPLE, e, advance(phase_q[e], fwd),
                     1'($urandom_range(0, 1))));
  endtask

  task automatic hold_off();
    @(negedge clk);
    in_valid = 1'b0;
    while (tap_expect_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [qdtq_pkg::CfgIdxWidth-1:0] idx,
                           logic [qdtq_pkg::ActionWidth-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      qdtq_pkg::CFG_ENC0_CW:  cw_action[0] = data;
      qdtq_pkg::CFG_ENC0_CCW: ccw_action[0] = data;
      qdtq_pkg::CFG_ENC1_CW:  cw_action[1] = data;
      qdtq_pkg::CFG_ENC1_CCW: ccw_action[1] = data;
      qdtq_pkg::CFG_SPD:      spd_reg = data[qdtq_pkg::SpdWidth-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(logic [15:0] a0, logic [15:0] a1, logic [15:0] a2,
                            logic [15:0] a3, logic [3:0] spd);
    hold_off();
    write_reg(qdtq_pkg::CFG_ENC0_CW, a0);
    write_reg(qdtq_pkg::CFG_ENC0_CCW, a1);
    write_reg(qdtq_pkg::CFG_ENC1_CW, a2);
    write_reg(qdtq_pkg::CFG_ENC1_CCW, a3);
    write_reg(qdtq_pkg::CFG_SPD, {12'h000, spd});
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (stall_en && $urandom_range(0, 3) == 0) begin
      out_stall = 1'b1;
      stall_left = idle_len() - 1;
    end else begin
      out_stall = 1'b0;
      stall_left = $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (tap_expect_q.size() == 0) begin
        if (err_count < 10) $display("unexpected transfer: %0h", out_data);
        err_count++;
      end else begin
        want = tap_expect_q.pop_front();
        if (out_data.tap_valid !== want.tap_valid || out_data.tap_mods !== want.tap_mods ||
            out_data.tap_key !== want.tap_key || out_data.queue_empty !== want.queue_empty ||
            out_data.queue_overflowed !== want.queue_overflowed) begin
          if (err_count < 10) begin
            $display("tap mismatch: want v%0b m%02h k%02h e%0b o%0b",
                     want.tap_valid, want.tap_mods, want.tap_key, want.queue_empty,
                     want.queue_overflowed);
            $display("              got  v%0b m%02h k%02h e%0b o%0b",
                     out_data.tap_valid, out_data.tap_mods, out_data.tap_key,
                     out_data.queue_empty, out_data.queue_overflowed);
          end
          err_count++;
        end
      end
    end
  end

  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int i;
    int ph;
    int sent;
    int r;
    int run;
    int slot_pct;
    int waited;
    bit paused;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    err_count = 0;
    idle_en = 1'b1;
    stall_en = 1'b1;
    cw_action[0] = qdtq_pkg::RST_ENC0_CW;
    ccw_action[0] = qdtq_pkg::RST_ENC0_CCW;
    cw_action[1] = qdtq_pkg::RST_ENC1_CW;
    ccw_action[1] = qdtq_pkg::RST_ENC1_CCW;
    spd_reg = qdtq_pkg::RST_SPD;
    for (i = 0; i < 2; i++) begin
      phase_q[i] = 2'd0;
      pend_q[i] = 0;
      detent_q[i] = 0;
    end
    for (i = 0; i < RingDepth; i++) ring_mem[i] = '0;
    wr_idx = '0;
    rd_idx = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (i = 0; i < DirRows; i++)
      send_item(DirTab[i].item, DirTab[i].fixed, DirTab[i].res);

    // overfill the tap ring from both encoders, then drain it
    idle_en = 1'b0;
    stall_en = 1'b0;
    set_config(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 4'd1);
    rotate(1'b0, 1'b1, FillRun);
    send(make_item(qdtq_pkg::OP_TICK, 1'b0, 2'd0, 1'b0));
    rotate(1'b1, 1'b0, 5);
    send(make_item(qdtq_pkg::OP_TICK, 1'b1, 2'd1, 1'b1));
    for (i = 0; i < RingDepth; i++) send(make_item(qdtq_pkg::OP_TICK, 1'b0, 2'd2, 1'b1));

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd0);
        1: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15);
        2: set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 4'd1);
        default: set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                            4'($urandom_range(0, 15)));
      endcase
      idle_en = (ph != 2);
      stall_en = (ph != 3);
      slot_pct = $urandom_range(20, 95);
      sent = 0;
      paused = 1'b0;
      while (sent < RandRun) begin
        if (!paused && sent >= RandRun / 2) begin
          hold_off();
          paused = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
          run = $urandom_range(1, 12);
          rotate(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), run);
          sent += run;
        end else begin
          if (r < 68)
            send(make_item(qdtq_pkg::OP_LOAD, 1'($urandom_range(0, 1)),
                           2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
          else if (r < 76)
            send(make_item(qdtq_pkg::OP_SAMPLE, 1'($urandom_range(0, 1)),
                           2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
          else if (r < 78)
            send(make_item(OP_SPARE, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                           1'($urandom_range(0, 1))));
          else
            send(make_item(qdtq_pkg::OP_TICK, 1'($urandom_range(0, 1)),
                           2'($urandom_range(0, 3)), ($urandom_range(0, 99) < slot_pct)));
          sent++;
        end
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    waited = 0;
    while (tap_expect_q.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (err_count == 0 && tap_expect_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
